### hw/rtl/gwm_pkg.sv
`default_nettype none

package gwm_pkg;

  localparam int unsigned GwmPatternDepth = 32;
  localparam int unsigned GwmCharBits     = 8;

  localparam logic [7:0] SymStar = 8'h2A;
  localparam logic [7:0] SymAny  = 8'h3F;

  typedef enum logic [1:0] {
    OpClear   = 2'd0,
    OpAppend  = 2'd1,
    OpSubject = 2'd2,
    OpEnd     = 2'd3
  } gwm_op_e;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } gwm_res_t;

endpackage

`default_nettype wire

### hw/rtl/gwm_item_if.sv
`default_nettype none

interface gwm_item_if import gwm_pkg::*; #(
  parameter int unsigned CharBits = GwmCharBits
);
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [CharBits-1:0] symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink   (input valid, input operation, input symbol, output ready);
endinterface

`default_nettype wire

### hw/rtl/gwm_res_if.sv
`default_nettype none

interface gwm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

### hw/rtl/gwm_nfa.sv
`default_nettype none

module gwm_nfa import gwm_pkg::*; #(
  parameter int unsigned PatternDepth = GwmPatternDepth,
  parameter int unsigned CharBits     = GwmCharBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire gwm_op_e             cmd_op_i,
  input  wire logic [CharBits-1:0] cmd_sym_i,
  output gwm_res_t                 res_o
);

  localparam int unsigned LenW = $clog2(PatternDepth + 1);
  localparam int unsigned IdxW = $clog2(PatternDepth);
  localparam logic [PatternDepth:0] ActStart = (PatternDepth + 1)'(1);

  logic [CharBits-1:0]     chr_q [PatternDepth];
  logic [PatternDepth-1:0] star_q, star_d, any_q, any_d;
  logic [PatternDepth-1:0] lmask_q, lmask_d;
  logic [LenW-1:0]         len_q, len_d;
  logic                    ovf_q, ovf_d;
  logic [PatternDepth:0]   act_q, act_d;

  logic                    full;
  logic                    wr_en;
  logic [IdxW-1:0]         widx;
  logic [PatternDepth-1:0] star_eff, match_v, stay, adv;
  logic [PatternDepth:0]   next_pre;
  logic [PatternDepth:0]   cl_a, cl_r, cl_sum;
  logic [PatternDepth-1:0] cl_s, cl_x, cl_y;

  assign full  = (len_q == LenW'(PatternDepth));
  assign wr_en = cmd_valid_i && (cmd_op_i == OpAppend) && !full;
  assign widx  = len_q[IdxW-1:0];

  // pattern write
  always_comb begin
    star_d = star_q;
    any_d  = any_q;
    if (wr_en) begin
      star_d[widx] = (cmd_sym_i == CharBits'(SymStar));
      any_d[widx]  = (cmd_sym_i == CharBits'(SymAny));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      chr_q[widx] <= cmd_sym_i;
    end
    star_q <= star_d;
    any_q  <= any_d;
  end

  // length, overflow
  always_comb begin
    len_d   = len_q;
    lmask_d = lmask_q;
    ovf_d   = ovf_q;
    if (cmd_valid_i) begin
      case (cmd_op_i)
        OpClear: begin
          len_d   = '0;
          lmask_d = '0;
          ovf_d   = 1'b0;
        end
        OpAppend: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d   = len_q + LenW'(1);
            lmask_d = {lmask_q[PatternDepth-2:0], 1'b1};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // subject step
  assign star_eff = star_q & lmask_q;

  always_comb begin
    for (int i = 0; i < PatternDepth; i++) begin
      match_v[i] = any_q[i] | (chr_q[i] == cmd_sym_i);
    end
  end

  assign stay     = act_q[PatternDepth-1:0] & star_eff;
  assign adv      = act_q[PatternDepth-1:0] & lmask_q & ~star_eff & match_v;
  assign next_pre = {1'b0, stay} | {adv, 1'b0};

  // star closure as a carry chain: r[i+1] = a[i+1] | (s[i] & r[i])
  assign cl_a   = (cmd_op_i == OpSubject) ? next_pre : ActStart;
  assign cl_s   = star_d & lmask_d;
  assign cl_y   = cl_a[PatternDepth:1];
  assign cl_x   = cl_s | cl_y;
  assign cl_sum = {1'b0, cl_x} + {1'b0, cl_y} + (PatternDepth + 1)'(cl_a[0]);
  assign cl_r   = {cl_sum[PatternDepth], cl_sum[PatternDepth-1:0] ^ cl_x ^ cl_y};

  assign act_d = cmd_valid_i ? cl_r : act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      lmask_q <= '0;
      ovf_q   <= 1'b0;
      act_q   <= ActStart;
    end else begin
      len_q   <= len_d;
      lmask_q <= lmask_d;
      ovf_q   <= ovf_d;
      act_q   <= act_d;
    end
  end

  assign res_o.matched          = act_q[len_q];
  assign res_o.pattern_overflow = ovf_q;

`ifndef SYNTHESIS
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && (cmd_op_i == OpClear) |=> (len_q == '0) && !ovf_q && (act_q == ActStart))
    else $error("clear did not restart the matcher");

  a_overflow_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && (cmd_op_i == OpAppend) && full |=> ovf_q && full)
    else $error("append past depth did not flag overflow");

  a_active_in_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q & ~{lmask_q, 1'b1}) == '0)
    else $error("active position beyond pattern end");

  a_lmask_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lmask_q) == int'(len_q))
    else $error("length mask out of step with length");
`endif

endmodule

`default_nettype wire

### hw/rtl/glob_wildcard_matcher.sv
// glob matcher: pattern loaded by clear/append items, subject streamed by character items
// result: registered into the result queue when an end-of-subject item is taken, then shown on res_o
// throughput: one item per cycle; a two-entry result queue keeps input open while a result waits
// input stalls only when both result entries are held by the sink
// reset: empty pattern, overflow clear, only position zero active, result queue empty
`default_nettype none

module glob_wildcard_matcher import gwm_pkg::*; #(
  parameter int unsigned PatternDepth = GwmPatternDepth,
  parameter int unsigned CharBits     = GwmCharBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gwm_item_if.sink  item_i,
  gwm_res_if.source res_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  gwm_op_e  op;
  logic     in_acc, end_acc, out_acc;
  gwm_res_t nfa_res;

  gwm_res_t        res_q [QDepth];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign op            = gwm_op_e'(item_i.operation);
  assign item_i.ready  = (cnt_q != CntW'(QDepth));
  assign in_acc        = item_i.valid && item_i.ready;
  assign end_acc       = in_acc && (op == OpEnd);
  assign out_acc       = res_o.valid && res_o.ready;

  gwm_nfa #(
    .PatternDepth (PatternDepth),
    .CharBits     (CharBits)
  ) u_nfa (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_acc),
    .cmd_op_i    (op),
    .cmd_sym_i   (item_i.symbol),
    .res_o       (nfa_res)
  );

  // result queue
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (end_acc) begin
      wr_d = ~wr_q;
    end
    if (out_acc) begin
      rd_d = ~rd_q;
    end
    case ({end_acc, out_acc})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      res_q[wr_q] <= nfa_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign res_o.valid            = (cnt_q != '0);
  assign res_o.matched          = res_q[rd_q].matched;
  assign res_o.pattern_overflow = res_q[rd_q].pattern_overflow;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("result queue overfilled");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> res_o.valid)
    else $error("end of subject gave no result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !end_acc |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("result queue count lost an item");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(1)) |-> (wr_q != rd_q))
    else $error("queue pointers out of step with count");
`endif

endmodule

`default_nettype wire
